// ----- hw/rtl/lzw_sc_pkg.sv -----
// lzw_sc_pkg: shared types and constants of the lzw stream compressor
// used by every module of the block but the checker, depends on nothing

package lzw_sc_pkg;

  localparam int unsigned MAX_CODE_BITS_DEF = 12;
  localparam int unsigned MIN_CODE_BITS     = 9;
  localparam int unsigned WIDTH_W           = 5;

  localparam logic [3:0]  CFG_RESET  = 4'd12;
  localparam logic [8:0]  CLEAR_CODE = 9'd256;
  localparam logic [8:0]  END_CODE   = 9'd257;
  localparam logic [8:0]  FIRST_CODE = 9'd258;
  localparam logic [31:0] HASH_MUL   = 32'd2654435761;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FINAL = 2'd1,
    KIND_END   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CMD_OPEN,
    CMD_OPEN_END,
    CMD_BYTE,
    CMD_BYTE_END,
    CMD_END,
    CMD_EMPTY
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               raw;
    logic               last;
    logic               flush;
    logic               done;
    logic [WIDTH_W-1:0] width;
  } pk_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_SWEEP,
    ST_CLR,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_PUT_PFX,
    ST_FULL_CLR,
    ST_END_PFX,
    ST_END_CODE
  } eng_state_e;

endpackage

// ----- hw/rtl/lzw_sc_front.sv -----
// lzw_sc_front: accepts input items, tracks block state, classifies each item
// into a command, queues it in a two-entry fifo, drops kind 3; uses lzw_sc_pkg

module lzw_sc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic [7:0]        data_byte_i,
  output logic              cmd_valid_o,
  output lzw_sc_pkg::cmd_t  cmd_o,
  input  logic              cmd_pop_i
);

  lzw_sc_pkg::cmd_t fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       in_block_q, in_block_d;
  logic       acc, push;
  lzw_sc_pkg::cmd_t new_cmd;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign acc         = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];

  always_comb begin
    new_cmd.data = data_byte_i;
    new_cmd.cmd  = lzw_sc_pkg::CMD_BYTE;
    push         = acc;
    in_block_d   = in_block_q;
    case (lzw_sc_pkg::kind_e'(kind_i))
      lzw_sc_pkg::KIND_DATA: begin
        new_cmd.cmd = in_block_q ? lzw_sc_pkg::CMD_BYTE : lzw_sc_pkg::CMD_OPEN;
        if (acc) in_block_d = 1'b1;
      end
      lzw_sc_pkg::KIND_FINAL: begin
        new_cmd.cmd = in_block_q ? lzw_sc_pkg::CMD_BYTE_END : lzw_sc_pkg::CMD_OPEN_END;
        if (acc) in_block_d = 1'b0;
      end
      lzw_sc_pkg::KIND_END: begin
        new_cmd.cmd = in_block_q ? lzw_sc_pkg::CMD_END : lzw_sc_pkg::CMD_EMPTY;
        if (acc) in_block_d = 1'b0;
      end
      default: push = 1'b0;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !cmd_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && cmd_pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= 1'b0;
      rptr_q     <= 1'b0;
      cnt_q      <= 2'd0;
      in_block_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      in_block_q <= in_block_d;
      if (push) wptr_q <= ~wptr_q;
      if (cmd_pop_i) rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= new_cmd;
  end

endmodule

// ----- hw/rtl/lzw_sc_pack.sv -----
// lzw_sc_pack: packs codes lsb first into bytes and holds the output register
// depends on lzw_sc_pkg

module lzw_sc_pack #(
  parameter int unsigned MaxCodeBits = lzw_sc_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lzw_sc_pkg::pk_req_t     req_i,
  input  logic [MaxCodeBits-1:0]  code_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    last_in_run_o,
  output logic                    block_done_o
);

  localparam int unsigned AW = MaxCodeBits + 7;
  localparam int unsigned WW = lzw_sc_pkg::WIDTH_W;

  logic          busy_q, busy_d;
  logic          raw_q, last_q, flush_q, done_q;
  logic [AW-1:0] acc_q, acc_d;
  logic [WW-1:0] cnt_q, cnt_d;
  logic [7:0]    raw_byte_q;
  logic          ov_q, ov_d;
  logic [7:0]    ob_q, ob_d;
  logic          ol_q, ol_d, od_q, od_d;
  logic          slot_free, take, fin;
  logic [WW-1:0] rem;
  logic [AW-1:0] code_mask;

  assign slot_free = !ov_q || !out_stall_i;
  assign ready_o   = !busy_q;
  assign take      = req_i.valid && !busy_q;
  assign rem       = cnt_q - WW'(8);
  assign code_mask = AW'((AW+1)'(1) << req_i.width) - AW'(1);

  always_comb begin
    busy_d = busy_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    ov_d   = ov_q && out_stall_i;
    ob_d   = ob_q;
    ol_d   = ol_q;
    od_d   = od_q;
    fin    = 1'b0;
    if (take) begin
      busy_d = 1'b1;
      if (!req_i.raw) begin
        acc_d = acc_q | ((AW'(code_i) & code_mask) << cnt_q);
        cnt_d = cnt_q + req_i.width;
      end
    end else if (busy_q && slot_free) begin
      ov_d = 1'b1;
      if (raw_q) begin
        ob_d = raw_byte_q;
        fin  = 1'b1;
      end else if (cnt_q >= WW'(8)) begin
        ob_d  = acc_q[7:0];
        acc_d = acc_q >> 8;
        cnt_d = rem;
        fin   = (rem < WW'(8)) && !(flush_q && (rem != '0));
      end else begin
        ob_d = acc_q[7:0];
        fin  = 1'b1;
      end
      if (fin && flush_q) begin
        acc_d = '0;
        cnt_d = '0;
      end
      ol_d   = fin && last_q;
      od_d   = fin && done_q;
      busy_d = !fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      acc_q  <= '0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
    od_q <= od_d;
    if (take) begin
      raw_q      <= req_i.raw;
      last_q     <= req_i.last;
      flush_q    <= req_i.flush;
      done_q     <= req_i.done;
      raw_byte_q <= code_i[7:0];
    end
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = ob_q;
  assign last_in_run_o = ol_q;
  assign block_done_o  = od_q;

endmodule

// ----- hw/rtl/lzw_sc_engine.sv -----
// lzw_sc_engine: dictionary sequencer with the hash table memory, runs one
// command at a time and feeds codes to the packer; depends on lzw_sc_pkg

module lzw_sc_engine #(
  parameter int unsigned MaxCodeBits = lzw_sc_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [3:0]              max_code_bits_i,
  input  logic                    cmd_valid_i,
  input  lzw_sc_pkg::cmd_t        cmd_i,
  output logic                    cmd_pop_o,
  output lzw_sc_pkg::pk_req_t     req_o,
  output logic [MaxCodeBits-1:0]  code_o,
  input  logic                    pk_ready_i
);

  localparam int unsigned CW    = MaxCodeBits;
  localparam int unsigned HB    = CW + 1;
  localparam int unsigned KW    = CW + 8;
  localparam int unsigned NW    = CW + 1;
  localparam int unsigned EW    = 1 + KW + CW;
  localparam int unsigned DEPTH = 1 << HB;
  localparam int unsigned WW    = lzw_sc_pkg::WIDTH_W;

  lzw_sc_pkg::eng_state_e state_q, state_d;

  lzw_sc_pkg::cmd_e cmd_q, cmd_d;
  logic [7:0]    byte_q, byte_d;
  logic [WW-1:0] blk_q, blk_d, cw_q, cw_d;
  logic [NW-1:0] nfc_q, nfc_d;
  logic [CW-1:0] prefix_q, prefix_d;
  logic [KW-1:0] key_q, key_d;
  logic [31:0]   prod_q, prod_d;
  logic [HB-1:0] h_q, h_d, sw_q, sw_d;
  logic          first_q, first_d;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;
  logic          we;
  logic [HB-1:0] wa, ra;
  logic [EW-1:0] wd;

  logic [WW-1:0]    mb, hbits;
  logic [HB:0]      one_sh;
  logic [HB-1:0]    hmask, hidx;
  logic [31:0]      prod_w;
  logic [NW-1:0]    limit, nfc_inc;
  logic             full, end_c, opening, rd_v, hit;
  logic [KW-1:0]    rd_key;
  logic [CW-1:0]    rd_code;

  always_comb begin
    mb = {1'b0, max_code_bits_i};
    if (mb < WW'(lzw_sc_pkg::MIN_CODE_BITS)) mb = WW'(lzw_sc_pkg::MIN_CODE_BITS);
    if (mb > WW'(MaxCodeBits)) mb = WW'(MaxCodeBits);
  end

  assign hbits   = blk_q + WW'(1);
  assign one_sh  = (HB+1)'(1) << hbits;
  assign hmask   = HB'(one_sh - (HB+1)'(1));
  assign hidx    = HB'(prod_q >> (6'd32 - {1'b0, hbits}));
  assign prod_w  = 32'({prefix_q, byte_q}) * lzw_sc_pkg::HASH_MUL;
  assign limit   = NW'(1) << blk_q;
  assign nfc_inc = nfc_q + NW'(1);
  assign full    = (nfc_q >= limit);
  assign end_c   = (cmd_q == lzw_sc_pkg::CMD_BYTE_END);
  assign opening = (cmd_q inside {lzw_sc_pkg::CMD_OPEN, lzw_sc_pkg::CMD_OPEN_END});
  assign rd_v    = rdata_q[EW-1];
  assign rd_key  = rdata_q[EW-2 -: KW];
  assign rd_code = rdata_q[CW-1:0];
  assign hit     = rd_v && (rd_key == key_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lzw_sc_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.cmd)
            lzw_sc_pkg::CMD_BYTE, lzw_sc_pkg::CMD_BYTE_END: state_d = lzw_sc_pkg::ST_HASH;
            lzw_sc_pkg::CMD_END: state_d = lzw_sc_pkg::ST_END_PFX;
            default: state_d = lzw_sc_pkg::ST_HDR;
          endcase
        end
      end
      lzw_sc_pkg::ST_HDR: begin
        if (pk_ready_i) begin
          state_d = (cmd_q == lzw_sc_pkg::CMD_EMPTY) ? lzw_sc_pkg::ST_CLR
                                                      : lzw_sc_pkg::ST_SWEEP;
        end
      end
      lzw_sc_pkg::ST_SWEEP: begin
        if (sw_q == hmask) begin
          if (opening) state_d = lzw_sc_pkg::ST_CLR;
          else state_d = end_c ? lzw_sc_pkg::ST_END_PFX : lzw_sc_pkg::ST_IDLE;
        end
      end
      lzw_sc_pkg::ST_CLR: begin
        if (pk_ready_i) begin
          case (cmd_q)
            lzw_sc_pkg::CMD_OPEN_END: state_d = lzw_sc_pkg::ST_END_PFX;
            lzw_sc_pkg::CMD_EMPTY:    state_d = lzw_sc_pkg::ST_END_CODE;
            default:                  state_d = lzw_sc_pkg::ST_IDLE;
          endcase
        end
      end
      lzw_sc_pkg::ST_HASH: state_d = lzw_sc_pkg::ST_READ;
      lzw_sc_pkg::ST_READ: state_d = lzw_sc_pkg::ST_CMP;
      lzw_sc_pkg::ST_CMP: begin
        if (hit) state_d = end_c ? lzw_sc_pkg::ST_END_PFX : lzw_sc_pkg::ST_IDLE;
        else if (rd_v) state_d = lzw_sc_pkg::ST_READ;
        else state_d = lzw_sc_pkg::ST_PUT_PFX;
      end
      lzw_sc_pkg::ST_PUT_PFX: begin
        if (pk_ready_i) begin
          if (full) state_d = lzw_sc_pkg::ST_FULL_CLR;
          else state_d = end_c ? lzw_sc_pkg::ST_END_PFX : lzw_sc_pkg::ST_IDLE;
        end
      end
      lzw_sc_pkg::ST_FULL_CLR: if (pk_ready_i) state_d = lzw_sc_pkg::ST_SWEEP;
      lzw_sc_pkg::ST_END_PFX:  if (pk_ready_i) state_d = lzw_sc_pkg::ST_END_CODE;
      lzw_sc_pkg::ST_END_CODE: if (pk_ready_i) state_d = lzw_sc_pkg::ST_IDLE;
      default: state_d = lzw_sc_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_pop_o = 1'b0;
    req_o     = '0;
    code_o    = '0;
    we        = 1'b0;
    wa        = h_q;
    wd        = '0;
    ra        = h_q;
    cmd_d     = cmd_q;
    byte_d    = byte_q;
    blk_d     = blk_q;
    cw_d      = cw_q;
    nfc_d     = nfc_q;
    prefix_d  = prefix_q;
    key_d     = key_q;
    prod_d    = prod_q;
    h_d       = h_q;
    sw_d      = sw_q;
    first_d   = first_q;
    case (state_q)
      lzw_sc_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i.cmd;
          byte_d    = cmd_i.data;
          first_d   = 1'b1;
          if (cmd_i.cmd inside {lzw_sc_pkg::CMD_OPEN, lzw_sc_pkg::CMD_OPEN_END,
                                lzw_sc_pkg::CMD_EMPTY}) begin
            blk_d = mb;
            cw_d  = WW'(lzw_sc_pkg::MIN_CODE_BITS);
            nfc_d = NW'(lzw_sc_pkg::FIRST_CODE);
            sw_d  = '0;
          end
        end
      end
      lzw_sc_pkg::ST_HDR: begin
        req_o.valid = 1'b1;
        req_o.raw   = 1'b1;
        code_o      = CW'(blk_q);
      end
      lzw_sc_pkg::ST_SWEEP: begin
        we   = 1'b1;
        wa   = sw_q;
        sw_d = sw_q + HB'(1);
      end
      lzw_sc_pkg::ST_CLR: begin
        req_o.valid = 1'b1;
        req_o.width = cw_q;
        req_o.last  = (cmd_q == lzw_sc_pkg::CMD_OPEN);
        code_o      = CW'(lzw_sc_pkg::CLEAR_CODE);
        if (pk_ready_i && cmd_q != lzw_sc_pkg::CMD_EMPTY) prefix_d = CW'(byte_q);
      end
      lzw_sc_pkg::ST_HASH: begin
        key_d  = {prefix_q, byte_q};
        prod_d = prod_w;
      end
      lzw_sc_pkg::ST_READ: begin
        ra      = first_q ? hidx : h_q;
        h_d     = ra;
        first_d = 1'b0;
      end
      lzw_sc_pkg::ST_CMP: begin
        if (hit) prefix_d = rd_code;
        else if (rd_v) h_d = (h_q + HB'(1)) & hmask;
      end
      lzw_sc_pkg::ST_PUT_PFX: begin
        req_o.valid = 1'b1;
        req_o.width = cw_q;
        req_o.last  = !end_c && !full;
        code_o      = prefix_q;
        if (pk_ready_i && !full) begin
          we       = 1'b1;
          wd       = {1'b1, key_q, nfc_q[CW-1:0]};
          nfc_d    = nfc_inc;
          prefix_d = CW'(byte_q);
          if (nfc_inc == (NW'(1) << cw_q) && cw_q < blk_q) cw_d = cw_q + WW'(1);
        end
      end
      lzw_sc_pkg::ST_FULL_CLR: begin
        req_o.valid = 1'b1;
        req_o.width = cw_q;
        req_o.last  = !end_c;
        code_o      = CW'(lzw_sc_pkg::CLEAR_CODE);
        if (pk_ready_i) begin
          cw_d     = WW'(lzw_sc_pkg::MIN_CODE_BITS);
          nfc_d    = NW'(lzw_sc_pkg::FIRST_CODE);
          prefix_d = CW'(byte_q);
          sw_d     = '0;
        end
      end
      lzw_sc_pkg::ST_END_PFX: begin
        req_o.valid = 1'b1;
        req_o.width = cw_q;
        code_o      = prefix_q;
      end
      lzw_sc_pkg::ST_END_CODE: begin
        req_o.valid = 1'b1;
        req_o.width = cw_q;
        req_o.last  = 1'b1;
        req_o.flush = 1'b1;
        req_o.done  = 1'b1;
        code_o      = CW'(lzw_sc_pkg::END_CODE);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lzw_sc_pkg::ST_IDLE;
      cmd_q    <= lzw_sc_pkg::CMD_BYTE;
      blk_q    <= WW'(MaxCodeBits);
      cw_q     <= WW'(lzw_sc_pkg::MIN_CODE_BITS);
      nfc_q    <= NW'(lzw_sc_pkg::FIRST_CODE);
      prefix_q <= '0;
      sw_q     <= '0;
      h_q      <= '0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      blk_q    <= blk_d;
      cw_q     <= cw_d;
      nfc_q    <= nfc_d;
      prefix_q <= prefix_d;
      sw_q     <= sw_d;
      h_q      <= h_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    key_q  <= key_d;
    prod_q <= prod_d;
  end

  // hash table: valid, key, code per entry
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rdata_q <= mem[ra];
  end

endmodule

// ----- hw/rtl/lzw_stream_compressor_unit.sv -----
// lzw_stream_compressor_unit: top level of the lzw stream compressor
// depends on lzw_sc_pkg, lzw_sc_front, lzw_sc_engine, lzw_sc_pack
//
// usage
//   input channel (in_valid_i, in_stall_o, kind_i, data_byte_i): one source
//   byte per transfer; kind 0 data, 1 final byte of block, 2 end of block,
//   3 is taken and dropped. output channel (out_valid_o, out_stall_i):
//   one compressed byte per transfer, last_in_run_o on the last byte an
//   input produced, block_done_o on the last byte of a block.
//   cfg channel (cfg_valid_i, cfg_ready_o, cfg_data_i) writes max_code_bits;
//   write it only while the block is idle. it is latched at block start.
// timing
//   a two-entry command queue sits between input and the dictionary engine.
//   a byte that extends the prefix goes through queue pop, hash multiply,
//   table read and compare, plus a read and compare per extra linear probe.
//   emitting a code adds a handover to the packer, which sends the bytes
//   one at a time unless stalled. a block start with data and every dictionary
//   clear sweep the 2^(max_code_bits+1) hash table entries (8192 at 12 bits).
// reset and stall
//   reset empties the queue, sets max_code_bits to 12, no output pending.
//   when the receiver stalls, the output byte holds, the packer and engine
//   wait, and the input stalls once the queue is full.

module lzw_stream_compressor_unit #(
  parameter int unsigned MaxCodeBits = lzw_sc_pkg::MAX_CODE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_in_run_o,
  output logic       block_done_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  logic [3:0] max_bits_q;
  logic       cmd_valid, cmd_pop, pk_ready;
  lzw_sc_pkg::cmd_t    cmd;
  lzw_sc_pkg::pk_req_t pk_req;
  logic [MaxCodeBits-1:0] pk_code;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bits_q <= lzw_sc_pkg::CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bits_q <= cfg_data_i;
    end
  end

  lzw_sc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  lzw_sc_engine #(.MaxCodeBits(MaxCodeBits)) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .max_code_bits_i (max_bits_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .req_o           (pk_req),
    .code_o          (pk_code),
    .pk_ready_i      (pk_ready)
  );

  lzw_sc_pack #(.MaxCodeBits(MaxCodeBits)) u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (pk_req),
    .code_i        (pk_code),
    .ready_o       (pk_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_in_run_o (last_in_run_o),
    .block_done_o  (block_done_o)
  );

endmodule

// ----- hw/rtl/lzw_sc_checker.sv -----
// lzw_sc_checker: port level assertions for lzw_stream_compressor_unit
// bound to the top level, depends on nothing else

module lzw_sc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] kind_i,
  input logic [7:0] data_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_in_run_o,
  input logic       block_done_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [3:0] cfg_data_i
);

  // a stalled output transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_in_run_o) && $stable(block_done_o))
    else $error("stalled output changed");

  // the end of a block is also the end of its input's run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_done_o |-> last_in_run_o)
    else $error("block_done without last_in_run");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind lzw_stream_compressor_unit lzw_sc_checker u_lzw_sc_checker (.*);

// ----- tb/lzw_stream_compressor_unit_tb.sv -----
// lzw_stream_compressor_unit_tb: self-checking bench for the lzw stream compressor
// scoreboard class predicts the compressed byte stream; depends on lzw_sc_pkg
`timescale 1ns / 1ps

module lzw_stream_compressor_unit_tb;

  localparam int unsigned HASH_SLOTS = 1 << (lzw_sc_pkg::MAX_CODE_BITS_DEF + 1);
  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       block_done;
  } cbyte_t;

  class lzw_scoreboard;
    bit [19:0] key_mem[HASH_SLOTS];
    bit [11:0] code_mem[HASH_SLOTS];
    bit        used_mem[HASH_SLOTS];
    bit [11:0] prefix;
    bit [12:0] free_code;
    bit [3:0]  cur_width;
    bit [6:0]  acc_bits;
    bit [2:0]  acc_cnt;
    bit        open;
    bit [3:0]  blk_limit;
    bit [3:0]  limit_reg;
    cbyte_t    pending_q[$];
    cbyte_t    step_q[$];
    int        mismatches;

    function new();
      prefix = 0; free_code = 258; cur_width = 9; acc_bits = 0; acc_cnt = 0;
      open = 0; blk_limit = 12; limit_reg = 12; mismatches = 0;
      foreach (used_mem[i]) used_mem[i] = 0;
    endfunction

    function void push_byte(bit [7:0] b);
      cbyte_t c;
      c.out_byte = b; c.last_in_run = 0; c.block_done = 0;
      step_q.push_back(c);
    endfunction

    function void put_code(bit [15:0] code, bit [3:0] w);
      bit [31:0] acc;
      int cnt;
      acc = acc_bits | ((code & ((1 << w) - 1)) << acc_cnt);
      cnt = acc_cnt + w;
      while (cnt >= 8) begin
        push_byte(acc[7:0]);
        acc = acc >> 8;
        cnt -= 8;
      end
      acc_bits = acc[6:0];
      acc_cnt = 3'(cnt);
    endfunction

    function void flush_acc();
      if (acc_cnt > 0) push_byte({1'b0, acc_bits});
      acc_bits = 0; acc_cnt = 0;
    endfunction

    function void wipe();
      foreach (used_mem[i]) used_mem[i] = 0;
      cur_width = 9; free_code = 258;
    endfunction

    function void open_block();
      bit [3:0] mb;
      mb = limit_reg;
      if (mb < 9) mb = 9;
      if (mb > 12) mb = 12;
      blk_limit = mb;
      push_byte({4'd0, mb});
      acc_bits = 0; acc_cnt = 0;
      wipe();
      put_code(16'(lzw_sc_pkg::CLEAR_CODE), cur_width);
    endfunction

    function void close_block();
      put_code(16'(prefix), cur_width);
      put_code(16'(lzw_sc_pkg::END_CODE), cur_width);
      flush_acc();
      open = 0;
      step_q[$].block_done = 1;
    endfunction

    function void absorb(bit [7:0] ch);
      int hb;
      bit [31:0] hmask, key, h, prod;
      int n;
      hb = blk_limit + 1;
      hmask = (1 << hb) - 1;
      key = 32'({prefix, ch});
      prod = key * lzw_sc_pkg::HASH_MUL;
      h = (prod >> (32 - hb)) & hmask;
      for (n = 0; n <= hmask && used_mem[h] && key_mem[h] != key[19:0]; n++)
        h = (h + 1) & hmask;
      if (used_mem[h] && key_mem[h] == key[19:0]) begin
        prefix = code_mem[h];
        return;
      end
      put_code(16'(prefix), cur_width);
      if (free_code < (1 << blk_limit)) begin
        if (!used_mem[h]) begin
          used_mem[h] = 1; key_mem[h] = key[19:0]; code_mem[h] = free_code[11:0];
        end
        free_code++;
        if (free_code == (1 << cur_width) && cur_width < blk_limit) cur_width++;
      end else begin
        put_code(16'(lzw_sc_pkg::CLEAR_CODE), cur_width);
        wipe();
      end
      prefix = 12'(ch);
    endfunction

    function void note_input(lzw_sc_pkg::kind_e kind, bit [7:0] ch);
      step_q.delete();
      if (kind == lzw_sc_pkg::KIND_NONE) return;
      if (kind == lzw_sc_pkg::KIND_END) begin
        if (open) close_block();
        else begin
          open_block();
          put_code(16'(lzw_sc_pkg::END_CODE), cur_width);
          flush_acc();
          step_q[$].block_done = 1;
        end
      end else begin
        if (!open) begin
          open_block(); prefix = 12'(ch); open = 1;
        end else absorb(ch);
        if (kind == lzw_sc_pkg::KIND_FINAL) close_block();
      end
      if (step_q.size() > 0) step_q[$].last_in_run = 1;
      foreach (step_q[i]) pending_q.push_back(step_q[i]);
    endfunction

    function void check_output(cbyte_t got);
      cbyte_t exp;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output byte %h", got.out_byte);
        return;
      end
      exp = pending_q.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp byte %h last %b done %b, got byte %h last %b done %b",
                   exp.out_byte, exp.last_in_run, exp.block_done,
                   got.out_byte, got.last_in_run, got.block_done);
      end
    endfunction
  endclass

  logic       clk_i, rst_ni;
  logic       in_valid_i, in_stall_o;
  logic [1:0] kind_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o, out_stall_i;
  logic [7:0] out_byte_o;
  logic       last_in_run_o, block_done_o;
  logic       cfg_valid_i, cfg_ready_o;
  logic [3:0] cfg_data_i;

  lzw_stream_compressor_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .data_byte_i,
    .out_valid_o, .out_stall_i, .out_byte_o, .last_in_run_o, .block_done_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  lzw_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int cycles;
  int items_sent;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // output side
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_output('{out_byte_o, last_in_run_o, block_done_o});
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(lzw_sc_pkg::kind_e kind, bit [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1; kind_i <= kind; data_byte_i <= ch;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(kind, ch);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending_q.size() > 0) @(negedge clk_i);
    repeat (9000) @(negedge clk_i);
  endtask

  task automatic write_limit(bit [3:0] v);
    cfg_valid_i <= 1; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.limit_reg = v;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic random_blocks(int count, int mode);
    bit [7:0] alpha;
    int r;
    alpha = 8'($urandom_range(1, 255));
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 80) send_item(lzw_sc_pkg::KIND_DATA, mode ? 8'($urandom) : 8'($urandom & alpha));
      else if (r < 88) send_item(lzw_sc_pkg::KIND_FINAL, 8'($urandom));
      else if (r < 95) send_item(lzw_sc_pkg::KIND_END, 8'($urandom));
      else send_item(lzw_sc_pkg::KIND_NONE, 8'($urandom));
    end
    send_item(lzw_sc_pkg::KIND_END, 8'h00);
  endtask

  initial begin
    sb = new();
    rst_ni = 0; in_valid_i = 0; kind_i = 0; data_byte_i = 0;
    out_stall_i = 0; cfg_valid_i = 0; cfg_data_i = 0;
    send_idle_pct = 0; recv_stall_pct = 0; items_sent = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: default limit, every kind and corner
    send_item(lzw_sc_pkg::KIND_END, 8'hff);
    send_item(lzw_sc_pkg::KIND_FINAL, 8'h00);
    send_item(lzw_sc_pkg::KIND_NONE, 8'hff);
    send_item(lzw_sc_pkg::KIND_DATA, 8'hff);
    send_item(lzw_sc_pkg::KIND_DATA, 8'hff);
    send_item(lzw_sc_pkg::KIND_DATA, 8'hff);
    send_item(lzw_sc_pkg::KIND_DATA, 8'h00);
    send_item(lzw_sc_pkg::KIND_DATA, 8'haa);
    send_item(lzw_sc_pkg::KIND_DATA, 8'h55);
    send_item(lzw_sc_pkg::KIND_FINAL, 8'hff);
    send_item(lzw_sc_pkg::KIND_DATA, 8'h12);
    send_item(lzw_sc_pkg::KIND_END, 8'h00);
    drain();

    // smallest limit
    write_limit(4'd9);
    send_idle_pct = 69;
    random_blocks(80, 1);
    drain();

    write_limit(4'd0);
    recv_stall_pct = 69; send_idle_pct = 0;
    random_blocks(40, 0);
    drain();

    write_limit(4'd15);
    recv_stall_pct = 15; send_idle_pct = 15;
    random_blocks(60, 0);
    drain();

    write_limit(4'd10);
    recv_stall_pct = 0; send_idle_pct = 0;
    random_blocks(60, 1);
    drain();

    write_limit(4'd12);
    random_blocks(50, 0);
    drain();

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
